[rtl/hkit_pkg.sv]
// Shared types and constants, including the FNV-1a hash constants, for the key intern table.
package hkit_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 1024;

   localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
   localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_PUT    = 2'd1,
      CMD_INTERN = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_FOUND       = 3'd0,
      ST_INSERTED    = 3'd1,
      ST_OVERWRITTEN = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   // One classified command as it travels from the front to the back.
   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  kind;
      logic [31:0] index;
      logic [31:0] parent;
      logic [31:0] value;
      logic [31:0] home;     // home slot, wide enough for any capacity
   } job_type;

endpackage

[rtl/hkit_ram.sv]
// Generic single-port RAM with registered read.
module hkit_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[rtl/hkit_front.sv]
// Front end: accepts commands and computes the FNV-1a home slot.
module hkit_front
   import hkit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  job_type in_job,
   output logic    job_valid,
   output job_type job,
   input  logic    job_take
);
   // Six stages: xor/multiply per word, each multiply split in 32-bit halves.
   // h*P mod 2^64 = hl*pl + ((hl*ph + hh*pl) << 32), with P high word 0x100.
   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] p0_ff, p0_in;
   logic [31:0] p1_ff, p1_in;
   logic        done_ff, done_in;
   job_type     j_ff, j_in;
   logic [31:0] word;

   always_comb begin
      case (step_ff)
         3'd0:    word = {24'd0, j_ff.kind};
         3'd2:    word = j_ff.index;
         default: word = j_ff.parent;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      h_in    = h_ff;
      p0_in   = p0_ff;
      p1_in   = p1_ff;
      done_in = done_ff;
      j_in    = j_ff;
      if (push && !full) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         h_in    = FNV_OFFSET;
         j_in    = in_job;
      end else if (busy_ff && !done_ff) begin
         if (!step_ff[0]) begin
            // multiply low halves, and cross terms
            p0_in = 64'(h_ff[31:0] ^ word) * 64'(FNV_PRIME[31:0]);
            p1_in = 32'((h_ff[31:0] ^ word) * FNV_PRIME[63:32])
                  + 32'(h_ff[63:32] * FNV_PRIME[31:0]);
            step_in = step_ff + 3'd1;
         end else begin
            h_in = p0_ff + {p1_ff, 32'd0};
            if (step_ff == 3'd5) begin
               done_in = 1'b1;
               j_in.home = h_in[31:0];
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
      end else if (done_ff && job_take) begin
         busy_in = 1'b0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      h_ff  <= h_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      j_ff  <= j_in;
   end

   assign full      = busy_ff;
   assign job_valid = done_ff;
   assign job       = j_ff;
endmodule

[rtl/hkit_back.sv]
// Back end: clears the used marks after reset, probes the table, applies the command, queues the response.
module hkit_back
   import hkit_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_take,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_value
);
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0] LAST = (AW+1)'(CAPACITY - 1);

   typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_READ, S_CHECK, S_OUT} state_type;

   state_type   state_ff;
   logic [AW-1:0] addr_ff;
   logic [AW:0]   cnt_ff;      // probes made, or clear position
   logic [CW-1:0] occ_ff;
   logic [31:0]   next_ff;
   job_type       j_ff;
   logic [2:0]    wk_st_ff;    // answer being built for the current job
   logic [31:0]   wk_val_ff;
   logic          out_v_ff;
   logic [2:0]    out_st_ff;
   logic [31:0]   out_val_ff;

   logic          we_used, we_key, we_val;
   logic          rd_used;
   logic [71:0]   rd_key;
   logic [31:0]   rd_val, wr_val;
   logic          hit, may_ins;

   hkit_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_used (
      .clock, .wr_en(we_used), .addr(addr_ff),
      .wr_data(state_ff != S_CLEAR), .rd_data(rd_used));
   hkit_ram #(.WIDTH(72), .DEPTH(CAPACITY)) u_key (
      .clock, .wr_en(we_key), .addr(addr_ff),
      .wr_data({j_ff.kind, j_ff.index, j_ff.parent}), .rd_data(rd_key));
   hkit_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
      .clock, .wr_en(we_val), .addr(addr_ff),
      .wr_data(wr_val), .rd_data(rd_val));

   assign hit     = rd_used && rd_key == {j_ff.kind, j_ff.index, j_ff.parent};
   assign may_ins = ((34'(occ_ff) + 34'd1) << 2) < 34'(CAPACITY) * 34'd3;
   assign wr_val  = (j_ff.cmd == CMD_INTERN) ? next_ff : j_ff.value;

   always_comb begin
      we_used = 1'b0;
      we_key  = 1'b0;
      we_val  = 1'b0;
      if (state_ff == S_CLEAR) begin
         we_used = 1'b1;
      end else if (state_ff == S_CHECK && (j_ff.cmd == CMD_PUT || j_ff.cmd == CMD_INTERN)) begin
         if (hit) begin
            we_val = (j_ff.cmd == CMD_PUT);
         end else if (!rd_used && may_ins) begin
            we_used = 1'b1;
            we_key  = 1'b1;
            we_val  = 1'b1;
         end
      end
   end

   assign job_take = (state_ff == S_IDLE) && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         cnt_ff   <= '0;
         occ_ff   <= '0;
         next_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && rsp_pop) begin
            out_v_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == LAST) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (job_valid) begin
                  j_ff      <= job;
                  addr_ff   <= AW'(job.home);
                  cnt_ff    <= '0;
                  state_ff  <= (job.cmd == CMD_NONE) ? S_OUT : S_READ;
                  wk_st_ff  <= ST_NOT_FOUND;
                  wk_val_ff <= '0;
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (hit) begin
                  wk_st_ff  <= (j_ff.cmd == CMD_PUT) ? ST_OVERWRITTEN : ST_FOUND;
                  wk_val_ff <= (j_ff.cmd == CMD_PUT) ? 32'd0 : rd_val;
                  state_ff  <= S_OUT;
               end else if (!rd_used || cnt_ff == LAST) begin
                  state_ff <= S_OUT;
                  if (j_ff.cmd != CMD_LOOKUP) begin
                     if (!rd_used && may_ins) begin
                        wk_st_ff <= ST_INSERTED;
                        occ_ff   <= occ_ff + 1'b1;
                        if (j_ff.cmd == CMD_INTERN) begin
                           wk_val_ff <= next_ff;
                           next_ff   <= next_ff + 32'd1;
                        end
                     end else begin
                        wk_st_ff <= ST_FULL;
                     end
                  end
               end else begin
                  // advance to next slot
                  addr_ff  <= (AW+1)'(addr_ff) == LAST ? '0 : addr_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_OUT: begin
               // hold until the previous response has been transferred
               if (!out_v_ff) begin
                  out_v_ff   <= 1'b1;
                  out_st_ff  <= wk_st_ff;
                  out_val_ff <= wk_val_ff;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_empty        = !out_v_ff;
   assign rsp_status       = out_st_ff;
   assign rsp_result_value = out_val_ff;

   a_occ: assert property (@(posedge clock) disable iff (reset)
      (CW+2)'(occ_ff) * 4 < (CW+2)'(CAPACITY) * 3 + 4)
      else $error("occupancy over limit");
   a_take: assert property (@(posedge clock) disable iff (reset)
      job_take |=> state_ff != S_IDLE)
      else $error("job taken without leaving idle");
   a_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !out_v_ff) |=> out_v_ff)
      else $error("response not posted");
endmodule

[rtl/hashed_key_intern_table_unit.sv]
// Top level of the hashed key intern table.
//
//   channel | direction | handshake    | payload
//   req     | in        | push / full  | cmd, key_kind, key_index, key_parent, put_value
//   rsp     | out       | pop / empty  | status, result_value
//
// A request passes the hash front (three 64-bit FNV-1a rounds, each a split
// multiply plus a fold), then the back: S_READ and S_CHECK for each probed slot,
// then S_OUT to post the response; the table RAM read port sets the probe pace.
// After reset the back clears the used marks of all CAPACITY slots; requests
// wait in the front meanwhile. The front takes the next request while the back
// probes, and the back finishes while an earlier response waits to be popped.
module hashed_key_intern_table_unit
   import hkit_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_key_kind,
   input  logic [31:0] req_key_index,
   input  logic [31:0] req_key_parent,
   input  logic [31:0] req_put_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_value
);
   job_type in_job, job;
   logic    job_valid, job_take;

   // pack request; home slot filled by the front
   always_comb begin
      in_job.cmd    = cmd_type'(req_cmd);
      in_job.kind   = req_key_kind;
      in_job.index  = req_key_index;
      in_job.parent = req_key_parent;
      in_job.value  = req_put_value;
      in_job.home   = '0;
   end

   hkit_front u_front (
      .clock, .reset, .push(req_push), .full(req_full), .in_job,
      .job_valid, .job, .job_take);

   hkit_back #(.CAPACITY(CAPACITY)) u_back (
      .clock, .reset, .job_valid, .job, .job_take,
      .rsp_empty, .rsp_pop, .rsp_status, .rsp_result_value);
endmodule
